FILE: sv/bal_pkg.sv
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and constants of the beam asymmetry log-likelihood block.
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int SUM_BITS_DEF   = 48;
  localparam int OUT_W          = 48;
  localparam int TERM_W         = 22;
  localparam int TAYLOR_STEPS   = 5;
  localparam int SQ_STEPS       = 16;

  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic signed [TERM_W-1:0] LOG_FLOOR_Q16 = TERM_W'(-32 * 65536);

  localparam logic CFG_POLARISATION = 1'b0;
  localparam logic CFG_ASYMMETRY    = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_TH, S_TH2, S_MUL, S_DIV, S_UPD, S_CS, S_PROD,
    S_VAL, S_NORM, S_SQ, S_ACC, S_OUT1, S_OUT2
  } state_e;

  typedef struct packed {
    logic load;
    logic th;
    logic th2;
    logic mul;
    logic div;
    logic upd;
    logic cs;
    logic prod;
    logic val;
    logic norm;
    logic sq;
    logic acc;
    logic out1;
    logic out2;
  } cmd_t;

  typedef struct packed {
    logic taylor_done;
    logic v_nonpos;
    logic norm_done;
    logic sq_done;
    logic last;
    logic out_free;
  } stat_t;

  // Series divisors 90, 56, 30, 12, 2 split into a right shift and an odd
  // factor; the odd factor is divided by reciprocal multiplication.
  function automatic logic [1:0] taylor_pre(input logic [2:0] k);
    logic [1:0] s;
    unique case (k)
      3'd0: s = 2'd1;
      3'd1: s = 2'd3;
      3'd2: s = 2'd1;
      3'd3: s = 2'd2;
      default: s = 2'd1;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] taylor_rcp(input logic [2:0] k);
    logic [31:0] r;
    unique case (k)
      3'd0: r = 32'd3054198967;
      3'd1: r = 32'd2454267027;
      3'd2: r = 32'd2290649225;
      3'd3: r = 32'd2863311531;
      default: r = 32'h8000_0000;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] taylor_post(input logic [2:0] k);
    logic [5:0] s;
    unique case (k)
      3'd0: s = 6'd37;
      3'd1: s = 6'd34;
      3'd2: s = 6'd35;
      3'd3: s = 6'd33;
      default: s = 6'd31;
    endcase
    return s;
  endfunction

endpackage

FILE: sv/bal_ctrl.sv
// ----------------------------------------------------------------------------
// bal_ctrl
// Sequencer: cosine, probability, log and sum per event; output after last.
// ----------------------------------------------------------------------------
module bal_ctrl import bal_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_TH;
        end
      end
      S_TH: begin
        cmd_o.th = 1'b1;
        state_d  = S_TH2;
      end
      S_TH2: begin
        cmd_o.th2 = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = stat_i.taylor_done ? S_CS : S_MUL;
      end
      S_CS: begin
        cmd_o.cs = 1'b1;
        state_d  = S_PROD;
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = S_VAL;
      end
      S_VAL: begin
        cmd_o.val = 1'b1;
        state_d   = stat_i.v_nonpos ? S_ACC : S_NORM;
      end
      S_NORM: begin
        cmd_o.norm = 1'b1;
        if (stat_i.norm_done) state_d = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        if (stat_i.sq_done) state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = stat_i.last ? S_OUT1 : S_IDLE;
      end
      S_OUT1: begin
        cmd_o.out1 = 1'b1;
        state_d    = S_OUT2;
      end
      S_OUT2: begin
        cmd_o.out2 = 1'b1;
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD && !stat_i.taylor_done) |=> state_q == S_MUL)
    else $error("taylor loop did not return to multiply");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_TH)
    else $error("accepted word did not start the sequence");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && !stat_i.last) |=> !in_stall_o)
    else $error("non-last word did not release the input");

endmodule

FILE: sv/bal_dp.sv
// ----------------------------------------------------------------------------
// bal_dp
// Datapath: cosine series, probability, log2, saturating sum and output.
// ----------------------------------------------------------------------------
module bal_dp import bal_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int SUM_BITS   = SUM_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  input  logic [ANGLE_BITS-1:0]   angle_code_i,
  input  logic                    polarisation_negative_i,
  input  logic                    last_event_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] log_likelihood_o,
  output logic                    clipped_o,
  input  cmd_t                    cmd_i,
  output stat_t                   stat_o
);

  logic [15:0]        pol_q;
  logic signed [15:0] asym_q;

  logic [ANGLE_BITS-1:0] ph;
  logic [15:0]           p16;

  assign ph = {angle_code_i[ANGLE_BITS-2:0], 1'b0};

  if (ANGLE_BITS >= 16) begin : g_wide
    assign p16 = ph[ANGLE_BITS-1 -: 16];
  end else begin : g_narrow
    assign p16 = {ph, {(16-ANGLE_BITS){1'b0}}};
  end

  logic [1:0]  quad_q;
  logic [14:0] r_q;
  logic        neg_q, last_q;
  logic [30:0] th_q;
  logic [31:0] th2_q;
  logic [30:0] a_q;
  logic [2:0]  k_q;
  logic [31:0] num_q;
  logic [31:0] quo_q;
  logic [15:0] cmag_q;
  logic        cneg_q;
  logic [31:0] pb_q;
  logic [47:0] m_q;
  logic [31:0] x_q;
  logic [4:0]  e_q;
  logic        flr_q;
  logic [30:0] lm_q;
  logic [15:0] frac_q;
  logic [3:0]  scnt_q;
  logic signed [SUM_BITS-1:0] log_sum_q;
  logic        clip_seen_q;
  logic [63:0] phi_q, plo_q;
  logic        sneg_q, oclip_q;

  logic [45:0] th_prod;
  logic [61:0] th2_prod;
  logic [62:0] t_prod;
  logic [30:0] dx;
  logic [62:0] q_prod;
  logic [30:0] a_plus;
  logic [15:0] c_raw, c_cap;
  logic [15:0] bmag;
  logic [33:0] cval;
  logic signed [35:0] v;
  logic [61:0] sq_prod;
  logic [31:0] sq_s;
  logic signed [5:0]  e_off;
  logic signed [TERM_W-1:0] term;
  logic signed [SUM_BITS:0] sum_ext;
  logic signed [63:0] s64;
  logic [63:0] mag, res, lim, res_sat;
  logic        res_over;

  assign th_prod  = r_q * HALF_PI_Q30;
  assign th2_prod = th_q * th_q;
  assign t_prod   = th2_q * a_q;
  assign dx       = 31'(num_q >> taylor_pre(k_q));
  assign q_prod   = dx * taylor_rcp(k_q);

  assign a_plus = a_q + 31'h4000;
  assign c_raw  = a_plus[30:15];
  assign c_cap  = (c_raw > 16'h8000) ? 16'h8000 : c_raw;
  assign bmag   = asym_q[15] ? 16'(-asym_q) : asym_q;
  assign cval   = 34'((49'(m_q) + 49'h4000) >> 15);
  assign v      = (neg_q ^ cneg_q) ? 36'(ONE_Q30) + 36'(cval)
                                   : 36'(ONE_Q30) - 36'(cval);
  assign sq_prod = lm_q * lm_q;
  assign sq_s    = sq_prod[61:30];
  assign e_off   = $signed({1'b0, e_q}) - 6'sd31;
  assign term    = flr_q ? LOG_FLOOR_Q16 : $signed({e_off, frac_q});
  assign sum_ext = (SUM_BITS+1)'(log_sum_q) + (SUM_BITS+1)'(term);

  assign s64      = 64'(log_sum_q);
  assign mag      = s64[63] ? 64'(-s64) : 64'(s64);
  assign res      = phi_q + ((plo_q + 64'h8000_0000) >> 32);
  assign lim      = sneg_q ? (64'd1 << 47) : ((64'd1 << 47) - 64'd1);
  assign res_over = res > lim;
  assign res_sat  = res_over ? lim : res;

  assign stat_o.taylor_done = k_q == 3'(TAYLOR_STEPS - 1);
  assign stat_o.v_nonpos    = v <= 0;
  assign stat_o.norm_done   = x_q[31];
  assign stat_o.sq_done     = scnt_q == 4'(SQ_STEPS - 1);
  assign stat_o.last        = last_q;
  assign stat_o.out_free    = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pol_q  <= '0;
      asym_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_POLARISATION: pol_q  <= cfg_data_i;
        CFG_ASYMMETRY:    asym_q <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quad_q <= p16[15:14];
      r_q    <= p16[14] ? 15'd16384 - {1'b0, p16[13:0]} : {1'b0, p16[13:0]};
      neg_q  <= polarisation_negative_i;
      last_q <= last_event_i;
      flr_q  <= 1'b0;
    end
    if (cmd_i.th) th_q <= th_prod[44:14];
    if (cmd_i.th2) begin
      th2_q <= th2_prod[61:30];
      a_q   <= ONE_Q30;
      k_q   <= '0;
    end
    if (cmd_i.mul) num_q <= t_prod[61:30];
    if (cmd_i.div) quo_q <= 32'(q_prod >> taylor_post(k_q));
    if (cmd_i.upd) begin
      a_q <= (quo_q > 32'(ONE_Q30)) ? '0 : 31'(32'(ONE_Q30) - quo_q);
      k_q <= k_q + 3'd1;
    end
    if (cmd_i.cs) begin
      cmag_q <= c_cap;
      cneg_q <= asym_q[15] ^ ((quad_q == 2'd1 || quad_q == 2'd2) && c_cap != 16'd0);
      pb_q   <= pol_q * bmag;
    end
    if (cmd_i.prod) m_q <= pb_q * cmag_q;
    if (cmd_i.val) begin
      x_q   <= v[31:0];
      e_q   <= 5'd31;
      flr_q <= v <= 0;
    end
    if (cmd_i.norm) begin
      if (x_q[31]) begin
        lm_q   <= x_q[31:1];
        frac_q <= '0;
        scnt_q <= '0;
      end else begin
        x_q <= {x_q[30:0], 1'b0};
        e_q <= e_q - 5'd1;
      end
    end
    if (cmd_i.sq) begin
      lm_q   <= sq_s[31] ? sq_s[31:1] : sq_s[30:0];
      frac_q <= {frac_q[14:0], sq_s[31]};
      scnt_q <= scnt_q + 4'd1;
    end
    if (cmd_i.out1) begin
      phi_q   <= mag[63:32] * LN2_Q32;
      plo_q   <= mag[31:0] * LN2_Q32;
      sneg_q  <= s64[63];
      oclip_q <= clip_seen_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_sum_q   <= '0;
      clip_seen_q <= 1'b0;
    end else if (cmd_i.out1) begin
      log_sum_q   <= '0;
      clip_seen_q <= 1'b0;
    end else if (cmd_i.acc) begin
      if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1]) begin
        log_sum_q   <= sum_ext[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                         : {1'b0, {(SUM_BITS-1){1'b1}}};
        clip_seen_q <= 1'b1;
      end else begin
        log_sum_q <= sum_ext[SUM_BITS-1:0];
      end
    end else if (cmd_i.val && v <= 0) begin
      clip_seen_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.out2 && stat_o.out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out2 && stat_o.out_free) begin
      log_likelihood_o <= sneg_q ? OUT_W'(-res_sat) : OUT_W'(res_sat);
      clipped_o        <= oclip_q | res_over;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.sq |-> lm_q[30])
    else $error("log mantissa not normalised");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd_i.out2))
    else $error("result word raised outside output step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out1 |=> (log_sum_q == '0 && !clip_seen_q))
    else $error("sum not cleared after last word");

endmodule

FILE: sv/beam_asymmetry_log_likelihood.sv
// ----------------------------------------------------------------------------
// beam_asymmetry_log_likelihood
// Event log-likelihood accumulator for a photon beam asymmetry fit.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): one word per event, angle code,
// polarisation sign and last-event mark. Output channel (out_valid_o /
// out_stall_i): one word per data set, the natural-log likelihood in Q.16
// and a clip flag, issued after the word marked last.
// Configuration: write photon_polarisation (index 0) and beam_asymmetry
// (index 1) through cfg_we_i while idle.
// Each event takes one word at a time through the shared sequencer:
// accept, the angle steps, the cosine series loop (multiply, reciprocal
// divide and update per term), the probability steps, normalisation, the
// squaring loop that yields the log fraction bit by bit, and the sum
// step; a floored probability skips the log stages. A last word adds the
// output steps. The bit-serial log dominates.
// Reset clears the sum, the flag and both registers. A stalled result
// holds in the output register; the block takes the next word meanwhile
// and waits only when a further result meets a full output register.
// ----------------------------------------------------------------------------
module beam_asymmetry_log_likelihood import bal_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF,
  parameter int SUM_BITS   = SUM_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [15:0]             cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [ANGLE_BITS-1:0]   angle_code_i,
  input  logic                    polarisation_negative_i,
  input  logic                    last_event_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] log_likelihood_o,
  output logic                    clipped_o
);

  cmd_t  cmd;
  stat_t stat;

  bal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bal_dp #(
    .ANGLE_BITS (ANGLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_dp (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_index_i             (cfg_index_i),
    .cfg_data_i              (cfg_data_i),
    .angle_code_i            (angle_code_i),
    .polarisation_negative_i (polarisation_negative_i),
    .last_event_i            (last_event_i),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .log_likelihood_o        (log_likelihood_o),
    .clipped_o               (clipped_o),
    .cmd_i                   (cmd),
    .stat_o                  (stat)
  );

endmodule
